// ----- rtl/pmrt_pkg.sv -----
// Shared constants and types for the pulse meter rate and total block.
package pmrt_pkg;

	localparam int METERS_DEF  = 5;
	localparam int HISTORY_DEF = 5;

	localparam int CNT_W    = 5;
	localparam int PPU_REGS = 5;

	localparam logic [2:0] REG_INTERVAL = 3'd5;
	localparam logic [2:0] REG_IDLE     = 3'd6;

	localparam logic [15:0] PPU_RESET      = 16'd1000;
	localparam logic [7:0]  INTERVAL_RESET = 8'd10;
	localparam logic [5:0]  IDLE_RESET     = 6'd30;

	localparam logic [29:0] RATE_SCALE = 30'd921600000;
	localparam logic [9:0]  MILLI      = 10'd1000;
	localparam logic [5:0]  LINE_MAX   = 6'd63;
	localparam logic [31:0] MAX32      = 32'hFFFF_FFFF;
	localparam logic [47:0] MAX48      = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [7:0] interval;
		logic [5:0] idle_limit;
	} cfg_t;

	typedef struct packed {
		logic [31:0]      total_seen;
		logic [31:0]      first_total;
		logic [47:0]      base;
		logic [5:0]       lines;
		logic [CNT_W-1:0] wpos;
		logic [CNT_W-1:0] fill;
		logic [31:0]      avg;
		logic             first_rep;
	} st_t;

	localparam st_t ST_INIT = '{
		total_seen: 32'd0, first_total: 32'd0, base: 48'd0, lines: 6'd0,
		wpos: '0, fill: '0, avg: 32'd0, first_rep: 1'b1
	};

endpackage

// ----- rtl/pmrt_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
module pmrt_div
	import pmrt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [47:0] quotient
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [31:0] rem_q;
	logic [47:0] quo_q;
	logic [31:0] div_q;
	logic [32:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[47]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == 6'd47);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd47)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(trial - {1'b0, div_q}) : trial[31:0];
			quo_q <= {quo_q[46:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/pmrt_cfg.sv -----
// Configuration registers with the per-meter pulses-per-unit lookup.
module pmrt_cfg
	import pmrt_pkg::*;
#(
	parameter int METERS = METERS_DEF,
	parameter int MW     = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [15:0]   cfg_data,
	input  logic [MW-1:0] sel,
	output logic [15:0]   ppu_sel,
	output cfg_t          cfg
);

	logic [15:0] ppu_q [METERS];
	cfg_t        cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < METERS; i++) begin
				ppu_q[i] <= PPU_RESET;
			end
			cfg_q.interval   <= INTERVAL_RESET;
			cfg_q.idle_limit <= IDLE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_INTERVAL: begin
					cfg_q.interval <= cfg_data[7:0];
				end
				REG_IDLE: begin
					cfg_q.idle_limit <= cfg_data[5:0];
				end
				default: begin
					for (int i = 0; i < METERS; i++) begin
						if ({1'b0, cfg_index} == 4'(i) && 32'(cfg_index) < PPU_REGS)
							ppu_q[i] <= cfg_data;
					end
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign ppu_sel   = ppu_q[sel];
	assign cfg       = cfg_q;

endmodule

// ----- rtl/pulse_meter_rate_and_total_top.sv -----
// Each report line uses the shared divider for up to four divisions (counter wrap, rate,
// history mean, and meter reading), and the history mean walks the filled entries of the
// history memory, reading and then accumulating each entry. The per-meter state sits in
// one memory and the usage history in another, both read through a registered read port.
// A new report is taken once the previous one has been written back, even while its
// result still waits in the output register. No clearing pass is needed after reset.
module pulse_meter_rate_and_total_top
	import pmrt_pkg::*;
#(
	parameter int METERS  = METERS_DEF,
	parameter int HISTORY = HISTORY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  meter_index,
	input  logic [15:0] pulses_in_interval,
	input  logic [31:0] total_pulse_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  meter_index_out,
	output logic [31:0] average_usage,
	output logic [47:0] counter_milli,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int MW    = (METERS > 1) ? $clog2(METERS) : 1;
	localparam int HD    = METERS * HISTORY;
	localparam int HAW   = (HD > 1) ? $clog2(HD) : 1;
	localparam int SUM_W = 32 + CNT_W;

	typedef enum logic [17:0] {
		S_IDLE  = 18'h00001,
		S_RD    = 18'h00002,
		S_LOAD  = 18'h00004,
		S_WGO   = 18'h00008,
		S_WWAIT = 18'h00010,
		S_WADD  = 18'h00020,
		S_PCHK  = 18'h00040,
		S_RGO   = 18'h00080,
		S_RWAIT = 18'h00100,
		S_HWR   = 18'h00200,
		S_SRD   = 18'h00400,
		S_SACC  = 18'h00800,
		S_AGO   = 18'h01000,
		S_AWAIT = 18'h02000,
		S_OCHK  = 18'h04000,
		S_OGO   = 18'h08000,
		S_OWAIT = 18'h10000,
		S_EMIT  = 18'h20000
	} state_t;

	state_t state_q, state_d;

	logic [2:0]        m_q;
	logic [15:0]       pulses_q;
	logic [31:0]       total_q;
	st_t               st_q;
	st_t               st_cur;
	st_t               st_ld;
	st_t               srd_q;
	logic [METERS-1:0] vld_q;
	logic [13:0]       lint_q;
	logic [HAW-1:0]    hbase_q;
	logic [31:0]       diff_q;
	logic [47:0]       milli_q;
	logic [31:0]       rate_q;
	logic [CNT_W-1:0]  k_q;
	logic [SUM_W-1:0]  sum_q;
	logic [31:0]       hdata_q;
	logic              emit_q;
	logic              out_valid_q;
	logic [2:0]        mo_q;
	logic [31:0]       avg_o_q;
	logic [47:0]       cnt_o_q;

	st_t         smem [METERS];
	logic [31:0] hmem [HD];

	logic [3:0]     m_ext;
	logic [MW-1:0]  m_idx;
	logic [15:0]    ppu_sel;
	cfg_t           cfg;
	logic [5:0]     lines_n;
	logic [31:0]    last;
	logic [31:0]    first_n;
	logic           emit_c;
	logic           out_free;
	logic [41:0]    milli_prod;
	logic [45:0]    rate_num;
	logic [29:0]    rate_den;
	logic [48:0]    sat_sum;
	logic [47:0]    sat_out;
	logic           div_start;
	logic [47:0]    div_a;
	logic [31:0]    div_b;
	logic           div_busy;
	logic           div_done;
	logic [47:0]    div_q;
	logic [HAW-1:0] haddr_w;
	logic [HAW-1:0] haddr_r;

	pmrt_cfg #(
		.METERS (METERS),
		.MW     (MW)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sel       (m_idx),
		.ppu_sel   (ppu_sel),
		.cfg       (cfg)
	);

	pmrt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	assign m_ext    = {1'b0, m_q};
	assign m_idx    = m_ext[MW-1:0];
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	assign st_cur  = vld_q[m_idx] ? srd_q : ST_INIT;
	assign lines_n = (st_cur.lines < LINE_MAX) ? st_cur.lines + 6'd1 : st_cur.lines;
	assign last    = st_cur.total_seen;
	assign first_n = (st_q.first_total == 32'd0) ? total_q : st_q.first_total;
	assign emit_c  = (total_q != 32'd0) || st_q.first_rep;

	always_comb begin
		st_ld            = st_cur;
		st_ld.lines      = lines_n;
		st_ld.total_seen = total_q;
	end

	assign milli_prod = diff_q * MILLI;
	assign rate_num   = RATE_SCALE * pulses_q;
	assign rate_den   = lint_q * ppu_sel;

	assign sat_sum = {1'b0, st_q.base} + {1'b0, milli_q};
	assign sat_out = sat_sum[48] ? MAX48 : sat_sum[47:0];

	assign haddr_w = hbase_q + HAW'(st_q.wpos);
	assign haddr_r = hbase_q + HAW'(k_q);

	always_comb begin
		div_start = 1'b0;
		div_a     = '0;
		div_b     = '0;
		case (state_q)
			S_WGO, S_OGO: begin
				div_a     = 48'(milli_prod);
				div_b     = 32'(ppu_sel);
				div_start = (diff_q != 32'd0) && (ppu_sel != 16'd0);
			end
			S_RGO: begin
				div_a     = 48'(rate_num);
				div_b     = 32'(rate_den);
				div_start = (rate_den != 30'd0);
			end
			S_AGO: begin
				div_a     = 48'(sum_q);
				div_b     = 32'(st_q.fill);
				div_start = 1'b1;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && 32'(meter_index) < METERS)
					state_d = S_RD;
			end
			S_RD: begin
				state_d = S_LOAD;
			end
			S_LOAD: begin
				state_d = (total_q < last) ? S_WGO : S_PCHK;
			end
			S_WGO: begin
				state_d = div_start ? S_WWAIT : S_WADD;
			end
			S_WWAIT: begin
				if (div_done)
					state_d = S_WADD;
			end
			S_WADD: begin
				state_d = S_PCHK;
			end
			S_PCHK: begin
				state_d = (pulses_q != 16'd0) ? S_RGO : S_OCHK;
			end
			S_RGO: begin
				state_d = div_start ? S_RWAIT : S_HWR;
			end
			S_RWAIT: begin
				if (div_done)
					state_d = S_HWR;
			end
			S_HWR: begin
				state_d = S_SRD;
			end
			S_SRD: begin
				state_d = S_SACC;
			end
			S_SACC: begin
				state_d = (k_q + 5'd1 == st_q.fill) ? S_AGO : S_SRD;
			end
			S_AGO: begin
				state_d = S_AWAIT;
			end
			S_AWAIT: begin
				if (div_done)
					state_d = S_OCHK;
			end
			S_OCHK: begin
				state_d = emit_c ? S_OGO : S_EMIT;
			end
			S_OGO: begin
				state_d = div_start ? S_OWAIT : S_EMIT;
			end
			S_OWAIT: begin
				if (div_done)
					state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			vld_q       <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_EMIT && out_free) begin
				vld_q[m_idx] <= 1'b1;
				out_valid_q  <= emit_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				m_q      <= meter_index;
				pulses_q <= pulses_in_interval;
				total_q  <= total_pulse_count;
			end
			S_LOAD: begin
				st_q    <= st_ld;
				lint_q  <= 14'(lines_n) * 14'(cfg.interval);
				hbase_q <= HAW'(32'(m_idx) * HISTORY);
				diff_q  <= (last > st_cur.first_total) ?
				           last - st_cur.first_total : 32'd0;
			end
			S_WGO, S_OGO: begin
				if (!div_start)
					milli_q <= (diff_q == 32'd0) ? 48'd0 : MAX48;
			end
			S_WWAIT, S_OWAIT: begin
				if (div_done)
					milli_q <= div_q;
			end
			S_WADD: begin
				st_q.base        <= sat_out;
				st_q.first_total <= total_q;
			end
			S_PCHK: begin
				if (pulses_q == 16'd0 && st_q.lines > cfg.idle_limit) begin
					st_q.lines <= 6'd0;
					st_q.wpos  <= '0;
					st_q.fill  <= '0;
					st_q.avg   <= 32'd0;
				end
			end
			S_RGO: begin
				if (!div_start)
					rate_q <= MAX32;
			end
			S_RWAIT: begin
				if (div_done)
					rate_q <= (|div_q[47:32]) ? MAX32 : div_q[31:0];
			end
			S_HWR: begin
				st_q.lines <= 6'd0;
				st_q.wpos  <= (st_q.wpos == CNT_W'(HISTORY - 1)) ? '0 : st_q.wpos + 5'd1;
				if (st_q.fill < CNT_W'(HISTORY))
					st_q.fill <= st_q.fill + 5'd1;
				k_q   <= '0;
				sum_q <= '0;
			end
			S_SACC: begin
				sum_q <= sum_q + SUM_W'(hdata_q);
				k_q   <= k_q + 5'd1;
			end
			S_AWAIT: begin
				if (div_done)
					st_q.avg <= div_q[31:0];
			end
			S_OCHK: begin
				emit_q <= emit_c;
				if (emit_c) begin
					st_q.first_rep   <= 1'b0;
					st_q.first_total <= first_n;
					diff_q           <= (total_q > first_n) ? total_q - first_n : 32'd0;
				end
			end
			S_EMIT: begin
				if (out_free && emit_q) begin
					mo_q    <= m_q;
					avg_o_q <= st_q.avg;
					cnt_o_q <= sat_out;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free)
			smem[m_idx] <= st_q;
		srd_q <= smem[m_idx];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_HWR)
			hmem[haddr_w] <= rate_q;
		hdata_q <= hmem[haddr_r];
	end

	assign out_valid       = out_valid_q;
	assign meter_index_out = mo_q;
	assign average_usage   = avg_o_q;
	assign counter_milli   = cnt_o_q;

`ifndef SYNTHESIS
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("Divider started while busy.");

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_free) |=> (state_q == S_IDLE))
		else $error("Write-back did not return to idle.");

	a_walk_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SACC) |-> (st_q.fill != '0))
		else $error("History walk with an empty history.");

	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EMIT))
		else $error("Result raised outside write-back.");
`endif

endmodule
